// ===== hdl/fwpid_pkg.sv =====
// package: shared types, constants and commands for the four wheel pid drive
package fwpid_pkg;
    localparam int WHEELS = 4;
    localparam int GAIN_FRAC_BITS = 8;
    localparam int WHL_W = $clog2(WHEELS);
    localparam int ERR_W = 17;
    localparam int DRV_W = 14;
    localparam int INNER_W = 42;
    localparam int PROD_W = INNER_W + 17;

    localparam logic [2:0] CFG_PROP_GAIN    = 3'd0;
    localparam logic [2:0] CFG_INTEG_GAIN   = 3'd1;
    localparam logic [2:0] CFG_DERIV_GAIN   = 3'd2;
    localparam logic [2:0] CFG_DRIVE_LIMIT  = 3'd3;
    localparam logic [2:0] CFG_PWM_PERIOD   = 3'd4;
    localparam logic [2:0] CFG_GEOMETRY_SUM = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TARGET,
        ST_INNER,
        ST_MULT,
        ST_DRIVE,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic             load;
        logic             target;
        logic             inner;
        logic             mult;
        logic             drive;
        logic [WHL_W-1:0] wheel;
        logic             out_load;
    } t_cmd;
endpackage

// ===== hdl/fwpid_ctrl.sv =====
// controller: sequences target, pid and output steps over the four wheels
module fwpid_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  logic            i_out_busy,
    output fwpid_pkg::t_cmd o_cmd
);
    import fwpid_pkg::*;

    t_state r_state, n_state;
    logic [WHL_W-1:0] r_wheel, n_wheel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_wheel <= '0;
        end else begin
            r_state <= n_state;
            r_wheel <= n_wheel;
        end
    end

    always_comb begin
        n_state = r_state;
        n_wheel = r_wheel;
        case (r_state)
            ST_IDLE:   if (i_in_valid) n_state = ST_TARGET;
            ST_TARGET: begin
                n_state = ST_INNER;
                n_wheel = '0;
            end
            ST_INNER:  n_state = ST_MULT;
            ST_MULT:   n_state = ST_DRIVE;
            ST_DRIVE: begin
                if (r_wheel == WHL_W'(WHEELS - 1)) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_INNER;
                    n_wheel = r_wheel + 1'b1;
                end
            end
            ST_OUT:    if (!i_out_busy) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.wheel = r_wheel;
        o_in_stall = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE:   o_cmd.load = i_in_valid;
            ST_TARGET: o_cmd.target = 1'b1;
            ST_INNER:  o_cmd.inner = 1'b1;
            ST_MULT:   o_cmd.mult = 1'b1;
            ST_DRIVE:  o_cmd.drive = 1'b1;
            ST_OUT:    o_cmd.out_load = !i_out_busy;
            default:   o_cmd = '0;
        endcase
    end
endmodule

// ===== hdl/fwpid_dp.sv =====
// datapath: kinematics, shared pid arithmetic, drive state and compare values
module fwpid_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  fwpid_pkg::t_cmd       i_cmd,
    input  logic signed [13:0]    i_cmd_vx,
    input  logic signed [13:0]    i_cmd_vy,
    input  logic signed [9:0]     i_cmd_w,
    input  logic signed [15:0]    i_enc_wheel0,
    input  logic signed [15:0]    i_enc_wheel1,
    input  logic signed [15:0]    i_enc_wheel2,
    input  logic signed [15:0]    i_enc_wheel3,
    input  logic [15:0]           i_prop_gain,
    input  logic [7:0]            i_integ_gain,
    input  logic [7:0]            i_deriv_gain,
    input  logic [12:0]           i_drive_limit,
    input  logic [12:0]           i_pwm_period,
    input  logic [7:0]            i_geometry_sum,
    output logic [12:0]           o_cmp [fwpid_pkg::WHEELS],
    output logic                  o_dir [fwpid_pkg::WHEELS]
);
    import fwpid_pkg::*;

    logic signed [13:0] r_vx, r_vy;
    logic signed [9:0]  r_w;
    logic signed [15:0] r_enc [WHEELS];
    logic signed [15:0] r_tgt [WHEELS];
    logic signed [ERR_W-1:0] r_le [WHEELS];
    logic signed [ERR_W-1:0] r_oe [WHEELS];
    logic signed [DRV_W-1:0] r_drv [WHEELS];
    logic signed [ERR_W-1:0] r_e;
    logic signed [INNER_W-1:0] r_inner;
    logic signed [PROD_W-1:0] r_prod;

    logic signed [18:0] s_r;
    logic signed [19:0] s_t [WHEELS];
    logic signed [ERR_W-1:0] s_e, s_pe, s_p2e;
    logic signed [INNER_W-1:0] s_inner;
    logic signed [PROD_W-1:0] s_inc;
    logic signed [PROD_W-1:0] s_sum;
    logic signed [DRV_W-1:0] s_d;
    logic signed [14:0] s_cmp [WHEELS];

    function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
        if (v > 20'sd32767) return 16'sh7fff;
        else if (v < -20'sd32768) return 16'sh8000;
        else return v[15:0];
    endfunction

    assign s_r = 19'(r_w) * $signed({11'd0, i_geometry_sum});
    assign s_t[0] = 20'(r_vy) - 20'(r_vx) + 20'(s_r);
    assign s_t[1] = 20'(r_vy) + 20'(r_vx) - 20'(s_r);
    assign s_t[2] = 20'(r_vx) - 20'(r_vy) + 20'(s_r);
    assign s_t[3] = -(20'(r_vy) + 20'(r_vx) + 20'(s_r));

    assign s_e   = ERR_W'(r_tgt[i_cmd.wheel]) - ERR_W'(r_enc[i_cmd.wheel]);
    assign s_pe  = r_le[i_cmd.wheel];
    assign s_p2e = r_oe[i_cmd.wheel];
    assign s_inner = (INNER_W'(s_e) - INNER_W'(s_pe)) * (INNER_W'(1) <<< GAIN_FRAC_BITS)
                   + INNER_W'(s_e) * $signed({1'b0, i_integ_gain})
                   + (INNER_W'(s_e) - 2 * INNER_W'(s_pe) + INNER_W'(s_p2e))
                     * $signed({1'b0, i_deriv_gain});

    // truncate toward zero
    assign s_inc = (r_prod < 0)
                 ? -((-r_prod) >>> (2 * GAIN_FRAC_BITS))
                 : (r_prod >>> (2 * GAIN_FRAC_BITS));
    assign s_sum = PROD_W'(r_drv[i_cmd.wheel]) + s_inc;
    assign s_d = (s_sum > $signed(PROD_W'(i_drive_limit))) ? DRV_W'(i_drive_limit)
               : (s_sum < -$signed(PROD_W'(i_drive_limit))) ? -DRV_W'(i_drive_limit)
               : s_sum[DRV_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_vx <= i_cmd_vx;
            r_vy <= i_cmd_vy;
            r_w  <= i_cmd_w;
            r_enc[0] <= i_enc_wheel0;
            r_enc[1] <= i_enc_wheel1;
            r_enc[2] <= i_enc_wheel2;
            r_enc[3] <= i_enc_wheel3;
        end
        if (i_cmd.target) begin
            for (int k = 0; k < WHEELS; k++) r_tgt[k] <= sat16(s_t[k]);
        end
        if (i_cmd.inner) begin
            r_e <= s_e;
            r_inner <= s_inner;
        end
        if (i_cmd.mult) r_prod <= PROD_W'(r_inner) * $signed({1'b0, i_prop_gain});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WHEELS; k++) begin
                r_le[k] <= '0;
                r_oe[k] <= '0;
                r_drv[k] <= '0;
            end
        end else if (i_cmd.drive) begin
            r_oe[i_cmd.wheel]  <= r_le[i_cmd.wheel];
            r_le[i_cmd.wheel]  <= r_e;
            r_drv[i_cmd.wheel] <= s_d;
        end
    end

    always_comb begin
        for (int k = 0; k < WHEELS; k++) begin
            s_cmp[k] = $signed({2'b0, i_pwm_period}) + 15'(r_drv[k]);
            o_dir[k] = !r_drv[k][DRV_W-1];
            if (o_dir[k]) o_cmp[k] = r_drv[k][12:0];
            else if (s_cmp[k] < 0) o_cmp[k] = '0;
            else o_cmp[k] = s_cmp[k][12:0];
        end
    end
endmodule

// ===== hdl/four_wheel_incremental_pid_drive_core.sv =====
// top level: four wheel incremental pid drive with config registers and output register
// Use: one input transfer per control tick carries vx, vy, w and four encoder counts.
// The block stalls the input while it works on a tick, then presents one result
// transfer holding a compare value and direction bit for each wheel.
// Sequence: setup and kinematics, then the inner, multiply and drive steps for each
// wheel in turn through the shared pid multiplier, then the output load; the
// next tick is taken the cycle after the result is loaded into the output
// register; no new tick is taken while one is still in work.
// The output register holds its result while the receiver stalls; a new result
// waits in the controller until that register is free, and the input stays stalled.
// Configuration writes are always ready and should be made while idle.
// Reset clears error history, drive values, control state and loads default gains.
// Unknown register indexes are ignored.
module four_wheel_incremental_pid_drive_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [13:0] i_cmd_vx,
    input  logic signed [13:0] i_cmd_vy,
    input  logic signed [9:0]  i_cmd_w,
    input  logic signed [15:0] i_enc_wheel0,
    input  logic signed [15:0] i_enc_wheel1,
    input  logic signed [15:0] i_enc_wheel2,
    input  logic signed [15:0] i_enc_wheel3,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [12:0]        o_cmp_wheel0,
    output logic               o_dir_wheel0,
    output logic [12:0]        o_cmp_wheel1,
    output logic               o_dir_wheel1,
    output logic [12:0]        o_cmp_wheel2,
    output logic               o_dir_wheel2,
    output logic [12:0]        o_cmp_wheel3,
    output logic               o_dir_wheel3,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    import fwpid_pkg::*;

    t_cmd s_cmd;
    logic r_valid;
    logic [15:0] r_prop_gain;
    logic [7:0]  r_integ_gain, r_deriv_gain, r_geometry_sum;
    logic [12:0] r_drive_limit, r_pwm_period;
    logic [12:0] s_cmp [WHEELS];
    logic        s_dir [WHEELS];
    logic [12:0] r_cmp [WHEELS];
    logic        r_dir [WHEELS];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain    <= 16'd3840;
            r_integ_gain   <= 8'd77;
            r_deriv_gain   <= 8'd102;
            r_drive_limit  <= 13'd7200;
            r_pwm_period   <= 13'd7200;
            r_geometry_sum <= 8'd20;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PROP_GAIN:    r_prop_gain    <= i_cfg_data;
                CFG_INTEG_GAIN:   r_integ_gain   <= i_cfg_data[7:0];
                CFG_DERIV_GAIN:   r_deriv_gain   <= i_cfg_data[7:0];
                CFG_DRIVE_LIMIT:  r_drive_limit  <= i_cfg_data[12:0];
                CFG_PWM_PERIOD:   r_pwm_period   <= i_cfg_data[12:0];
                CFG_GEOMETRY_SUM: r_geometry_sum <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    fwpid_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .o_in_stall (o_stall),
        .i_out_busy (r_valid && i_stall),
        .o_cmd      (s_cmd)
    );

    fwpid_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (s_cmd),
        .i_cmd_vx       (i_cmd_vx),
        .i_cmd_vy       (i_cmd_vy),
        .i_cmd_w        (i_cmd_w),
        .i_enc_wheel0   (i_enc_wheel0),
        .i_enc_wheel1   (i_enc_wheel1),
        .i_enc_wheel2   (i_enc_wheel2),
        .i_enc_wheel3   (i_enc_wheel3),
        .i_prop_gain    (r_prop_gain),
        .i_integ_gain   (r_integ_gain),
        .i_deriv_gain   (r_deriv_gain),
        .i_drive_limit  (r_drive_limit),
        .i_pwm_period   (r_pwm_period),
        .i_geometry_sum (r_geometry_sum),
        .o_cmp          (s_cmp),
        .o_dir          (s_dir)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_cmd.out_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_cmd.out_load) begin
            r_cmp <= s_cmp;
            r_dir <= s_dir;
        end
    end

    assign o_valid = r_valid;
    assign o_cmp_wheel0 = r_cmp[0];
    assign o_dir_wheel0 = r_dir[0];
    assign o_cmp_wheel1 = r_cmp[1];
    assign o_dir_wheel1 = r_dir[1];
    assign o_cmp_wheel2 = r_cmp[2];
    assign o_dir_wheel2 = r_dir[2];
    assign o_cmp_wheel3 = r_cmp[3];
    assign o_dir_wheel3 = r_dir[3];
endmodule

// ===== verif/tb_top.sv =====
// testbench for the four wheel incremental pid drive core: random ticks checked against a predictor
`timescale 1ns / 1ps
module tb_top;
    import fwpid_pkg::*;

    typedef struct packed {
        logic [12:0] cmp0; logic dir0;
        logic [12:0] cmp1; logic dir1;
        logic [12:0] cmp2; logic dir2;
        logic [12:0] cmp3; logic dir3;
    } t_wheel_out;

    class drive_scoreboard;
        longint kp, ki, kd, lim, period, geom;
        longint last_err[WHEELS];
        longint older_err[WHEELS];
        longint drv[WHEELS];
        t_wheel_out pending[$];
        int errors;

        function void init();
            kp = 3840; ki = 77; kd = 102; lim = 7200; period = 7200; geom = 20;
            for (int k = 0; k < WHEELS; k++) begin
                last_err[k] = 0; older_err[k] = 0; drv[k] = 0;
            end
            errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [15:0] val);
            case (idx)
                CFG_PROP_GAIN:    kp = val;
                CFG_INTEG_GAIN:   ki = val[7:0];
                CFG_DERIV_GAIN:   kd = val[7:0];
                CFG_DRIVE_LIMIT:  lim = val[12:0];
                CFG_PWM_PERIOD:   period = val[12:0];
                CFG_GEOMETRY_SUM: geom = val[7:0];
                default: ;
            endcase
        endfunction

        function void note_tick(logic signed [13:0] vx, logic signed [13:0] vy,
                                logic signed [9:0] w, logic signed [15:0] enc[4]);
            longint r, t, e, pe, p2e, inner, prod, inc, d, c;
            longint tgt[4];
            logic [12:0] cmps[4];
            logic dirs[4];
            r = longint'(w) * geom;
            tgt[0] = vy - vx + r;
            tgt[1] = vy + vx - r;
            tgt[2] = vx - vy + r;
            tgt[3] = -(longint'(vy) + vx + r);
            for (int k = 0; k < WHEELS; k++) begin
                t = tgt[k] < -32768 ? -32768 : (tgt[k] > 32767 ? 32767 : tgt[k]);
                e = t - enc[k];
                pe = last_err[k];
                p2e = older_err[k];
                inner = (e - pe) * (1 << GAIN_FRAC_BITS) + ki * e + kd * (e - 2 * pe + p2e);
                prod = kp * inner;
                inc = prod / (longint'(1) << (2 * GAIN_FRAC_BITS));
                d = drv[k] + inc;
                if (d > lim) d = lim;
                if (d < -lim) d = -lim;
                older_err[k] = pe;
                last_err[k] = e;
                drv[k] = d;
                if (d >= 0) begin
                    c = d; dirs[k] = 1'b1;
                end else begin
                    c = period + d;
                    if (c < 0) c = 0;
                    dirs[k] = 1'b0;
                end
                cmps[k] = c[12:0];
            end
            pending.push_back({cmps[0], dirs[0], cmps[1], dirs[1],
                               cmps[2], dirs[2], cmps[3], dirs[3]});
        endfunction

        function void check_result(t_wheel_out got);
            t_wheel_out want;
            if (pending.size() == 0) begin
                $display("%0t unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.cmp0 !== want.cmp0 || got.dir0 !== want.dir0 ||
                got.cmp1 !== want.cmp1 || got.dir1 !== want.dir1 ||
                got.cmp2 !== want.cmp2 || got.dir2 !== want.dir2 ||
                got.cmp3 !== want.cmp3 || got.dir3 !== want.dir3) begin
                $display("%0t mismatch expected cmp %0d/%0d %0d/%0d %0d/%0d %0d/%0d",
                         $time, want.cmp0, want.dir0, want.cmp1, want.dir1,
                         want.cmp2, want.dir2, want.cmp3, want.dir3);
                $display("%0t           actual   cmp %0d/%0d %0d/%0d %0d/%0d %0d/%0d",
                         $time, got.cmp0, got.dir0, got.cmp1, got.dir1,
                         got.cmp2, got.dir2, got.cmp3, got.dir3);
                errors++;
            end
        endfunction
    endclass

    logic i_clk, i_rst_n;
    logic i_valid, o_stall, o_valid, i_stall;
    logic signed [13:0] i_cmd_vx, i_cmd_vy;
    logic signed [9:0] i_cmd_w;
    logic signed [15:0] i_enc_wheel0, i_enc_wheel1, i_enc_wheel2, i_enc_wheel3;
    logic [12:0] o_cmp_wheel0, o_cmp_wheel1, o_cmp_wheel2, o_cmp_wheel3;
    logic o_dir_wheel0, o_dir_wheel1, o_dir_wheel2, o_dir_wheel3;
    logic i_cfg_valid, o_cfg_ready;
    logic [2:0] i_cfg_index;
    logic [15:0] i_cfg_data;

    drive_scoreboard sb;
    int unsigned cycles;
    bit hold_off;
    bit stall_burst;

    four_wheel_incremental_pid_drive_core dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0; i_valid = 1'b0; i_stall = 1'b0; i_cfg_valid = 1'b0;
        i_cfg_index = '0; i_cfg_data = '0;
        i_cmd_vx = '0; i_cmd_vy = '0; i_cmd_w = '0;
        i_enc_wheel0 = '0; i_enc_wheel1 = '0; i_enc_wheel2 = '0; i_enc_wheel3 = '0;
        sb = new();
        sb.init();
        hold_off = 1'b0; stall_burst = 1'b0;
        cycles = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver: random stalls, plus one long forced hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall)
                sb.check_result({o_cmp_wheel0, o_dir_wheel0, o_cmp_wheel1, o_dir_wheel1,
                                 o_cmp_wheel2, o_dir_wheel2, o_cmp_wheel3, o_dir_wheel3});
            if (hold_off) i_stall <= 1'b1;
            else if (stall_burst) i_stall <= ($urandom_range(0, 9) < 7);
            else i_stall <= ($urandom_range(0, 3) == 0);
        end
    end

    initial begin
        forever begin
            #($urandom_range(2000, 20000) * 1ns);
            stall_burst = ~stall_burst;
        end
    end

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
        if (n > 0) i_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic send_tick(logic signed [13:0] vx, logic signed [13:0] vy,
                             logic signed [9:0] w, logic signed [15:0] e0,
                             logic signed [15:0] e1, logic signed [15:0] e2,
                             logic signed [15:0] e3);
        logic signed [15:0] enc[4];
        enc[0] = e0; enc[1] = e1; enc[2] = e2; enc[3] = e3;
        i_valid <= 1'b1;
        i_cmd_vx <= vx; i_cmd_vy <= vy; i_cmd_w <= w;
        i_enc_wheel0 <= e0; i_enc_wheel1 <= e1; i_enc_wheel2 <= e2; i_enc_wheel3 <= e3;
        do @(posedge i_clk); while (o_stall);
        sb.note_tick(vx, vy, w, enc);
    endtask

    task automatic send_random(bit full_range);
        logic signed [15:0] e[4];
        logic signed [13:0] vx, vy;
        logic signed [9:0] w;
        vx = $urandom; vy = $urandom; w = $urandom;
        if (!full_range) begin
            vx = $signed($urandom_range(0, 1200)) - 600;
            vy = $signed($urandom_range(0, 1200)) - 600;
            w = $signed($urandom_range(0, 40)) - 20;
        end
        for (int k = 0; k < 4; k++) begin
            e[k] = $urandom;
            if (!full_range) e[k] = $signed($urandom_range(0, 200)) - 100;
        end
        send_tick(vx, vy, w, e[0], e[1], e[2], e[3]);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, val);
    endtask

    task automatic config_set(logic [15:0] kp, logic [15:0] ki, logic [15:0] kd,
                              logic [15:0] lim, logic [15:0] per, logic [15:0] geo);
        drain();
        write_reg(CFG_PROP_GAIN, kp);
        write_reg(CFG_INTEG_GAIN, ki);
        write_reg(CFG_DERIV_GAIN, kd);
        write_reg(CFG_DRIVE_LIMIT, lim);
        write_reg(CFG_PWM_PERIOD, per);
        write_reg(CFG_GEOMETRY_SUM, geo);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes at reset settings
        send_tick(14'sh1FFF, 14'sh1FFF, 10'sh1FF, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000);
        send_tick(14'sh2000, 14'sh2000, 10'sh200, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
        send_tick('0, '0, '0, '0, '0, '0, '0);
        send_tick(14'sh1FFF, 14'sh2000, 10'sh1FF, 16'sh0, 16'shFFFF, 16'sh1, 16'sh0);
        send_tick(14'sh2000, 14'sh1FFF, 10'sh200, 16'sh1234, 16'shEDCB, 16'sh0, 16'sh0);

        // limit above period: negative compare saturates to zero
        config_set(16'hFFFF, 16'hFF, 16'hFF, 16'h1FFF, 16'd100, 16'hFF);
        send_tick(14'sh2000, 14'sh1FFF, 10'sh1FF, 16'sh7FFF, 16'sh8000, 16'sh0, 16'sh7FFF);
        send_tick(14'sh1FFF, 14'sh2000, 10'sh200, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh0);
        send_tick('0, '0, '0, 16'sh0100, 16'shFF00, 16'sh0, 16'sh0);
        // zero limit, zero period, bogus index, oversized data
        config_set(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        write_reg(3'd6, 16'hFFFF);
        write_reg(3'd7, 16'h1234);
        i_cfg_valid <= 1'b0;
        send_tick(14'sh1FFF, 14'sh2000, 10'sh1FF, 16'sh7FFF, 16'sh8000, 16'sh0, 16'sh1);
        config_set(16'd256, 16'hFF10, 16'hE020, 16'hE000, 16'hFFFF, 16'h0101);
        send_tick(14'sh0100, 14'sh0200, 10'sh010, 16'sh0, 16'sh0, 16'sh0, 16'sh0);
        send_tick(14'sh2000, 14'sh1FFF, 10'sh200, 16'sh0, 16'sh0, 16'sh0, 16'sh0);
        config_set(16'd3840, 16'd77, 16'd102, 16'd7200, 16'd7200, 16'd20);

        // long receiver hold-off while ticks keep coming
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            repeat (6) send_random(1'b0);
        join

        for (int phase = 0; phase < 8; phase++) begin
            if (phase > 0)
                config_set($urandom, $urandom_range(0, 255), $urandom_range(0, 255),
                           (phase == 3) ? 16'h1FFF : $urandom_range(0, 8191),
                           (phase == 4) ? 16'd1 : $urandom_range(1, 8191),
                           $urandom_range(0, 255));
            for (int n = 0; n < 100; n++) begin
                if ($urandom_range(0, 4) != 0) idle_gap();
                send_random($urandom_range(0, 3) == 0);
            end
            drain();
        end

        drain();
        if (sb.errors == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
